### rtl/psms_pkg.sv
// ----------------------------------------------------------------------------
// psms_pkg: shared types and constants
// Item and result payloads, readout request and response, field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package psms_pkg;

	localparam int STEP_W   = 10;
	localparam int SAMPLE_W = 24;
	localparam int SUM_W    = 36;
	localparam int SQ_W     = 60;
	localparam int N_W      = 12;

	localparam logic [N_W-1:0] RUN_COUNT_RESET = 12'd2;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef struct packed {
		op_t                        operation;
		logic [STEP_W-1:0]          step_index;
		logic signed [SAMPLE_W-1:0] sample_value;
	} item_t;

	typedef struct packed {
		logic [STEP_W-1:0]          out_step;
		logic signed [SAMPLE_W-1:0] mean_value;
		logic [SAMPLE_W-1:0]        std_value;
	} result_t;

	typedef struct packed {
		logic              start;
		logic              in_range;
		logic [STEP_W-1:0] step;
		logic [N_W-1:0]    n;
		logic [SUM_W-1:0]  sum;
		logic [SQ_W-1:0]   sq;
	} stat_req_t;

	typedef struct packed {
		logic    done;
		result_t result;
	} stat_rsp_t;

endpackage

`default_nettype wire

### rtl/per_step_mean_and_std_engine.sv
// ----------------------------------------------------------------------------
// per_step_mean_and_std_engine: per-step mean and sample std
// Sum and sum-of-squares per step in one RAM; adds do read-modify-write,
// readouts run the arithmetic sequencer and clear the entry.
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  item     | item_valid, item_stall, item     | in, stall out
//  result   | result_valid, result_stall, result | out, stall in
//  cfg      | cfg_valid, cfg_ready, cfg_data   | in, ready out
//
//  adds: one beat per cycle unless stalled, read-modify-write with forwarding
//  readout: item side stalls until the result of the bit-serial divide,
//  multiply and root sequencer is loaded into the result register
//  reset: clearing pass over every entry, item side stalled meanwhile
//  result register lets adds proceed while a result waits on result_stall
// ----------------------------------------------------------------------------
`default_nettype none

module per_step_mean_and_std_engine import psms_pkg::*; #(
	parameter int STEP_COUNT = 1024
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_stall,
	input  wire item_t          item,
	output logic                result_valid,
	input  wire logic           result_stall,
	output result_t             result,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [N_W-1:0] cfg_data
);

	localparam int ADDR_W = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
	localparam int IDX_W  = 17;
	localparam int ENT_W  = SUM_W + SQ_W;

	logic [N_W-1:0]       run_count_q;
	logic                 clr_q;
	logic [ADDR_W-1:0]    clr_addr_q;
	logic                 busy_q;
	logic                 item_acc;

	logic                 v_s1;
	op_t                  op_s1;
	logic [STEP_W-1:0]    idx_s1;
	logic                 ok_s1;
	logic [SAMPLE_W-1:0]  sample_s1;

	logic                 v_s2;
	op_t                  op_s2;
	logic [STEP_W-1:0]    idx_s2;
	logic                 ok_s2;
	logic [SAMPLE_W-1:0]  sample_s2;
	logic [47:0]          prod_s2;
	logic [SUM_W-1:0]     sum_s2;
	logic [SQ_W-1:0]      sq_s2;

	logic                 wb_v_q;
	logic [ADDR_W-1:0]    wb_addr_q;
	logic [ENT_W-1:0]     wb_data_q;

	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [ENT_W-1:0]     ram_wdata;
	logic [ENT_W-1:0]     ram_rdata;
	logic [ADDR_W-1:0]    item_addr;
	logic                 item_ok;
	logic [ADDR_W-1:0]    addr_s1;
	logic [ADDR_W-1:0]    addr_s2;
	logic [SAMPLE_W-1:0]  smag_s1;
	logic [ENT_W-1:0]     old_s1;
	logic [ENT_W-1:0]     new_s2;

	logic                 result_valid_q;
	result_t              result_q;
	stat_req_t            stat_req;
	stat_rsp_t            stat_rsp;
	logic                 take;

	logic [IDX_W-1:0]     item_idx_w;
	logic [IDX_W-1:0]     idx_s1_w;
	logic [IDX_W-1:0]     idx_s2_w;

	assign item_idx_w = {7'd0, item.step_index};
	assign idx_s1_w   = {7'd0, idx_s1};
	assign idx_s2_w   = {7'd0, idx_s2};
	assign item_addr  = item_idx_w[ADDR_W-1:0];
	assign addr_s1    = idx_s1_w[ADDR_W-1:0];
	assign addr_s2    = idx_s2_w[ADDR_W-1:0];
	assign item_ok    = item_idx_w < IDX_W'(STEP_COUNT);

	assign cfg_ready  = 1'b1;
	assign item_stall = clr_q | busy_q;
	assign item_acc   = item_valid & ~item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q <= RUN_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			run_count_q <= cfg_data;
		end
	end

	// clearing pass over the whole store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(STEP_COUNT - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	psms_ram #(
		.WIDTH (ENT_W),
		.DEPTH (STEP_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (item_acc),
		.raddr (item_addr),
		.rdata (ram_rdata)
	);

	// stage 1: ram data arrives, square the sample, pick the newest entry
	assign smag_s1 = sample_s1[SAMPLE_W-1] ? (~sample_s1 + 24'd1) : sample_s1;

	always_comb begin
		if (v_s2 && ok_s2 && idx_s2 == idx_s1) begin
			old_s1 = new_s2;
		end else if (wb_v_q && wb_addr_q == addr_s1) begin
			old_s1 = wb_data_q;
		end else begin
			old_s1 = ram_rdata;
		end
	end

	// stage 2: accumulate or clear, write back
	assign new_s2 = (op_s2 == OP_READ) ? '0
		: {sum_s2 + {{(SUM_W - SAMPLE_W){sample_s2[SAMPLE_W-1]}}, sample_s2},
		   sq_s2 + {12'd0, prod_s2}};

	assign ram_we    = clr_q | (v_s2 & ok_s2);
	assign ram_waddr = clr_q ? clr_addr_q : addr_s2;
	assign ram_wdata = clr_q ? '0 : new_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			wb_v_q <= 1'b0;
		end else begin
			v_s1   <= item_acc;
			v_s2   <= v_s1;
			wb_v_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		op_s1     <= item.operation;
		idx_s1    <= item.step_index;
		ok_s1     <= item_ok;
		sample_s1 <= item.sample_value;
		op_s2     <= op_s1;
		idx_s2    <= idx_s1;
		ok_s2     <= ok_s1;
		sample_s2 <= sample_s1;
		prod_s2   <= smag_s1 * smag_s1;
		sum_s2    <= old_s1[ENT_W-1:SQ_W];
		sq_s2     <= old_s1[SQ_W-1:0];
		wb_addr_q <= ram_waddr;
		wb_data_q <= ram_wdata;
	end

	assign stat_req.start    = v_s2 & (op_s2 == OP_READ);
	assign stat_req.in_range = ok_s2;
	assign stat_req.step     = idx_s2;
	assign stat_req.n        = run_count_q;
	assign stat_req.sum      = sum_s2;
	assign stat_req.sq       = sq_s2;

	psms_stat u_stat (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (stat_req),
		.take   (take),
		.rsp    (stat_rsp)
	);

	assign take = stat_rsp.done & (~result_valid_q | ~result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_acc && item.operation == OP_READ) begin
				busy_q <= 1'b1;
			end else if (take) begin
				busy_q <= 1'b0;
			end
			if (take) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= stat_rsp.result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_read_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat_req.start |-> busy_q)
		else $error("readout reached stage 2 without the busy interlock");

	a_result_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(stat_rsp.done))
		else $error("result beat without a finished readout");

	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !v_s1 && !v_s2)
		else $error("item in flight during the clearing pass");
`endif

endmodule

`default_nettype wire

### rtl/psms_ram.sv
// ----------------------------------------------------------------------------
// psms_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module psms_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/psms_stat.sv
// ----------------------------------------------------------------------------
// psms_stat: readout arithmetic sequencer
// Mean by restoring division, n*sumsq and sum^2 by shift-add, variance by
// restoring division, std by digit-by-digit square root. One bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psms_stat import psms_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire stat_req_t req,
	input  wire logic      take,
	output stat_rsp_t      rsp
);

	localparam int NUM_W  = 72;
	localparam int DIV_W  = 24;
	localparam int ROOT_W = 24;
	localparam int RREM_W = 26;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAN,
		ST_MUL_NSQ,
		ST_MUL_SS,
		ST_SUB,
		ST_VAR,
		ST_ROOT,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [6:0]            cnt_q;
	logic [STEP_W-1:0]     step_q;
	logic [N_W-1:0]        n_q;
	logic                  neg_q;
	logic [SUM_W-1:0]      mag_q;
	logic [SQ_W-1:0]       sq_q;
	logic [NUM_W-1:0]      num_q;
	logic [NUM_W-1:0]      acc_q;
	logic [SUM_W-1:0]      mplr_q;
	logic [NUM_W-1:0]      dvd_q;
	logic [DIV_W-1:0]      div_q;
	logic [DIV_W-1:0]      rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [RREM_W-1:0]     rtrem_q;
	logic [SAMPLE_W-1:0]   mean_q;
	logic [SAMPLE_W-1:0]   std_q;

	logic [SUM_W-1:0]      req_mag;
	logic [DIV_W:0]        div_trial;
	logic                  div_ge;
	logic [DIV_W:0]        div_diff;
	logic [DIV_W-1:0]      rem_next;
	logic [NUM_W-1:0]      dvd_next;
	logic [NUM_W-1:0]      mcand;
	logic [NUM_W-1:0]      acc_next;
	logic [RREM_W+1:0]     root_trial;
	logic [RREM_W+1:0]     root_sub;
	logic                  root_ge;
	logic [DIV_W-1:0]      n_pair;

	function automatic logic [SAMPLE_W-1:0] mean_sat(input logic neg,
		input logic [SUM_W-1:0] q);
		logic [SAMPLE_W-1:0] r;
		if (!neg) begin
			r = (q > SUM_W'(24'h7FFFFF)) ? 24'h7FFFFF : q[SAMPLE_W-1:0];
		end else begin
			r = (q > SUM_W'(24'h800000)) ? 24'h800000 : (~q[SAMPLE_W-1:0] + 24'd1);
		end
		return r;
	endfunction

	assign req_mag   = req.sum[SUM_W-1] ? (~req.sum + 36'd1) : req.sum;

	assign div_trial = {rem_q, dvd_q[NUM_W-1]};
	assign div_ge    = div_trial >= {1'b0, div_q};
	assign div_diff  = div_trial - {1'b0, div_q};
	assign rem_next  = div_ge ? div_diff[DIV_W-1:0] : div_trial[DIV_W-1:0];
	assign dvd_next  = {dvd_q[NUM_W-2:0], div_ge};

	assign mcand    = (state_q == ST_MUL_NSQ) ? {12'd0, sq_q} : {36'd0, mag_q};
	assign acc_next = {acc_q[NUM_W-2:0], 1'b0} + (mplr_q[SUM_W-1] ? mcand : '0);

	// next two radicand bits come from the top of the 48-bit quotient
	assign root_trial = {rtrem_q, dvd_q[47:46]};
	assign root_sub   = {2'b00, root_q, 2'b01};
	assign root_ge    = root_trial >= root_sub;

	assign n_pair = DIV_W'(n_q) * DIV_W'(n_q - 12'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			step_q  <= '0;
			n_q     <= '0;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			sq_q    <= '0;
			num_q   <= '0;
			acc_q   <= '0;
			mplr_q  <= '0;
			dvd_q   <= '0;
			div_q   <= '0;
			rem_q   <= '0;
			root_q  <= '0;
			rtrem_q <= '0;
			mean_q  <= '0;
			std_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						step_q <= req.step;
						n_q    <= req.n;
						neg_q  <= req.sum[SUM_W-1];
						mag_q  <= req_mag;
						sq_q   <= req.sq;
						mean_q <= '0;
						std_q  <= '0;
						dvd_q  <= {req_mag, 36'd0};
						rem_q  <= '0;
						div_q  <= DIV_W'(req.n);
						cnt_q  <= 7'd35;
						if (!req.in_range || req.n == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MEAN;
						end
					end
				end
				ST_MEAN: begin
					dvd_q <= dvd_next;
					rem_q <= rem_next;
					if (cnt_q == '0) begin
						mean_q <= mean_sat(neg_q, dvd_next[SUM_W-1:0]);
						acc_q  <= '0;
						mplr_q <= {n_q, 24'd0};
						cnt_q  <= 7'd11;
						// a single run has no spread
						state_q <= (n_q == 12'd1) ? ST_DONE : ST_MUL_NSQ;
					end else begin
						cnt_q <= cnt_q - 7'd1;
					end
				end
				ST_MUL_NSQ: begin
					if (cnt_q == '0) begin
						num_q   <= acc_next;
						acc_q   <= '0;
						mplr_q  <= mag_q;
						cnt_q   <= 7'd35;
						state_q <= ST_MUL_SS;
					end else begin
						acc_q  <= acc_next;
						mplr_q <= {mplr_q[SUM_W-2:0], 1'b0};
						cnt_q  <= cnt_q - 7'd1;
					end
				end
				ST_MUL_SS: begin
					acc_q  <= acc_next;
					mplr_q <= {mplr_q[SUM_W-2:0], 1'b0};
					cnt_q  <= cnt_q - 7'd1;
					if (cnt_q == '0) begin
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					if (num_q <= acc_q) begin
						state_q <= ST_DONE;
					end else begin
						dvd_q   <= num_q - acc_q;
						rem_q   <= '0;
						div_q   <= n_pair;
						cnt_q   <= 7'd71;
						state_q <= ST_VAR;
					end
				end
				ST_VAR: begin
					dvd_q <= dvd_next;
					rem_q <= rem_next;
					if (cnt_q == '0) begin
						root_q  <= '0;
						rtrem_q <= '0;
						cnt_q   <= 7'd23;
						if (dvd_next[NUM_W-1:48] != '0) begin
							std_q   <= 24'hFFFFFF;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_ROOT;
						end
					end else begin
						cnt_q <= cnt_q - 7'd1;
					end
				end
				ST_ROOT: begin
					rtrem_q <= root_ge ? RREM_W'(root_trial - root_sub)
						: RREM_W'(root_trial);
					root_q  <= {root_q[ROOT_W-2:0], root_ge};
					dvd_q   <= {dvd_q[NUM_W-3:0], 2'b00};
					cnt_q   <= cnt_q - 7'd1;
					if (cnt_q == '0) begin
						std_q   <= {root_q[ROOT_W-2:0], root_ge};
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.done              = (state_q == ST_DONE);
	assign rsp.result.out_step   = step_q;
	assign rsp.result.mean_value = mean_q;
	assign rsp.result.std_value  = std_q;

endmodule

`default_nettype wire
